// ----- design/cv2alu_pkg.sv -----
// Shared constants, command and status codes of the checked vector ALU.
`default_nettype none
package cv2alu_pkg;

  localparam int unsigned FieldW       = 64;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatW        = 3;
  localparam int unsigned DataWidthDef = 64;
  localparam int unsigned InTdataW     = 4 * FieldW;
  localparam int unsigned OutTdataW    = 3 * FieldW;

  typedef enum logic [CmdW-1:0] {
    CmdAdd   = 3'd0,
    CmdSub   = 3'd1,
    CmdMul   = 3'd2,
    CmdDiv   = 3'd3,
    CmdDot   = 3'd4,
    CmdCross = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk   = 3'd0,
    StOvf  = 3'd1,
    StUnf  = 3'd2,
    StDiv  = 3'd3,
    StSovf = 3'd4
  } status_e;

endpackage
`default_nettype wire

// ----- design/checked_vec2_int_alu_unit.sv -----
// Top level: pipelined checked integer ALU for two-component vectors.
`default_nettype none
// One transfer is taken per cycle unless the output stalls. The depth is set
// by the restoring divider, one quotient bit per stage for both lanes; add,
// subtract, multiply, dot and cross ride the same stages so results leave in
// order. Multiplies use four half-width partial products per lane. A stall at
// the output freezes the whole pipeline.
module checked_vec2_int_alu_unit #(
  parameter int unsigned DATA_WIDTH = cv2alu_pkg::DataWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_x, a_y, b_x, b_y
  input  wire logic [cv2alu_pkg::InTdataW-1:0]  s_axis_tdata,
  // command
  input  wire logic [cv2alu_pkg::CmdW-1:0]      s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // vec_x, vec_y, scalar_out
  output logic [cv2alu_pkg::OutTdataW-1:0]      m_axis_tdata,
  // status
  output logic [cv2alu_pkg::StatW-1:0]          m_axis_tuser
);
  import cv2alu_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned HW = (W + 1) / 2;
  localparam int unsigned PW = 2 * HW;

  typedef logic [W-1:0]      word_t;
  typedef logic [PW-1:0]     pp_t;
  typedef logic [2*PW-1:0]   prod_t;
  typedef logic [2*W-1:0]    acc_t;

  localparam word_t MinW   = {1'b1, {(W-1){1'b0}}};
  localparam prod_t MinMag = (2*PW)'(1) << (W-1);

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    word_t [1:0]     a;
    word_t [1:0]     b;
  } a_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    word_t [1:0]     a;
    word_t [1:0]     s;
    logic            as_err;
    word_t [1:0]     ma;
    word_t [1:0]     mb;
    logic [1:0]      mneg;
    word_t [1:0]     dn;
    word_t [1:0]     dd;
    logic [1:0]      qn;
    logic            dfault;
  } b_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    word_t [1:0]     a;
    word_t [1:0]     s;
    logic            as_err;
    pp_t [1:0][3:0]  pp;
    logic [1:0]      mneg;
    word_t [1:0]     dn;
    word_t [1:0]     dd;
    logic [1:0]      qn;
    logic            dfault;
  } c_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    word_t [1:0]     a;
    word_t [1:0]     s;
    logic            as_err;
    prod_t [1:0]     prod;
    logic [1:0]      mneg;
    word_t [1:0]     dn;
    word_t [1:0]     dd;
    logic [1:0]      qn;
    logic            dfault;
  } d_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    word_t [1:0]     a;
    word_t [1:0]     s;
    logic            as_err;
    word_t [1:0]     t;
    logic [1:0]      mok;
    logic [1:0]      mneg;
    word_t [1:0]     dn;
    word_t [1:0]     dd;
    logic [1:0]      qn;
    logic            dfault;
  } e_t;

  typedef struct packed {
    word_t [1:0] r;
    word_t       sc;
    status_e     st;
    logic        isdiv;
    logic [1:0]  qn;
    acc_t [1:0]  acc;
    word_t [1:0] dd;
  } dv_t;

  typedef struct packed {
    logic [FieldW-1:0] vx;
    logic [FieldW-1:0] vy;
    logic [FieldW-1:0] sc;
    status_e           st;
  } m_t;

  function automatic word_t mag(input word_t v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic acc_t dstep(input acc_t acc, input word_t dv);
    logic [W:0] top;
    logic [W:0] dif;
    top = acc[2*W-1:W-1];
    dif = top - {1'b0, dv};
    if (!dif[W]) begin
      dstep = {dif[W-1:0], acc[W-2:0], 1'b1};
    end else begin
      dstep = {acc[2*W-2:0], 1'b0};
    end
  endfunction

  function automatic dv_t dstage(input dv_t s);
    dv_t n;
    n = s;
    n.acc[0] = dstep(s.acc[0], s.dd[0]);
    n.acc[1] = dstep(s.acc[1], s.dd[1]);
    dstage = n;
  endfunction

  logic en;
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, m_vld_q;
  logic [W-1:0] dv_vld_q;
  a_t  a_q;
  b_t  b_d, b_q;
  c_t  c_d, c_q;
  d_t  d_d, d_q;
  e_t  e_d, e_q;
  dv_t f_d, f_q;
  dv_t dv_q [W];
  m_t  m_d, m_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {m_q.sc, m_q.vy, m_q.vx};
  assign m_axis_tuser  = m_q.st;

  // stage B: add/sub with range check, operand magnitudes
  always_comb begin
    logic [1:0][W:0] sum;
    logic [1:0][W:0] dif;
    logic            is_cross;
    logic [1:0]      ovf;
    logic [1:0]      unf;
    logic [1:0]      df;
    is_cross = (a_q.cmd == CmdCross);
    for (int i = 0; i < 2; i++) begin
      sum[i] = {a_q.a[i][W-1], a_q.a[i]} + {a_q.b[i][W-1], a_q.b[i]};
      dif[i] = {a_q.a[i][W-1], a_q.a[i]} - {a_q.b[i][W-1], a_q.b[i]};
      ovf[i] = sum[i][W] ^ sum[i][W-1];
      unf[i] = dif[i][W] ^ dif[i][W-1];
      df[i]  = (a_q.b[i] == '0) || (a_q.a[i] == MinW && a_q.b[i] == '1);
    end
    b_d.cmd    = a_q.cmd;
    b_d.a      = a_q.a;
    if (a_q.cmd == CmdSub) begin
      b_d.s[0]   = dif[0][W-1:0];
      b_d.s[1]   = dif[1][W-1:0];
      b_d.as_err = |unf;
    end else begin
      b_d.s[0]   = sum[0][W-1:0];
      b_d.s[1]   = sum[1][W-1:0];
      b_d.as_err = |ovf;
    end
    b_d.ma[0]   = mag(a_q.a[0]);
    b_d.ma[1]   = mag(a_q.a[1]);
    b_d.mb[0]   = mag(is_cross ? a_q.b[1] : a_q.b[0]);
    b_d.mb[1]   = mag(is_cross ? a_q.b[0] : a_q.b[1]);
    b_d.mneg[0] = a_q.a[0][W-1] ^ (is_cross ? a_q.b[1][W-1] : a_q.b[0][W-1]);
    b_d.mneg[1] = a_q.a[1][W-1] ^ (is_cross ? a_q.b[0][W-1] : a_q.b[1][W-1]);
    b_d.dn[0]   = mag(a_q.a[0]);
    b_d.dn[1]   = mag(a_q.a[1]);
    b_d.dd[0]   = mag(a_q.b[0]);
    b_d.dd[1]   = mag(a_q.b[1]);
    b_d.qn[0]   = a_q.a[0][W-1] ^ a_q.b[0][W-1];
    b_d.qn[1]   = a_q.a[1][W-1] ^ a_q.b[1][W-1];
    b_d.dfault  = |df;
  end

  // stage C: half-width partial products
  always_comb begin
    pp_t ea;
    pp_t eb;
    c_d.cmd    = b_q.cmd;
    c_d.a      = b_q.a;
    c_d.s      = b_q.s;
    c_d.as_err = b_q.as_err;
    c_d.mneg   = b_q.mneg;
    c_d.dn     = b_q.dn;
    c_d.dd     = b_q.dd;
    c_d.qn     = b_q.qn;
    c_d.dfault = b_q.dfault;
    for (int i = 0; i < 2; i++) begin
      ea = PW'(b_q.ma[i]);
      eb = PW'(b_q.mb[i]);
      c_d.pp[i][0] = PW'(ea[HW-1:0])  * PW'(eb[HW-1:0]);
      c_d.pp[i][1] = PW'(ea[HW-1:0])  * PW'(eb[PW-1:HW]);
      c_d.pp[i][2] = PW'(ea[PW-1:HW]) * PW'(eb[HW-1:0]);
      c_d.pp[i][3] = PW'(ea[PW-1:HW]) * PW'(eb[PW-1:HW]);
    end
  end

  // stage D: full product magnitude
  always_comb begin
    d_d.cmd    = c_q.cmd;
    d_d.a      = c_q.a;
    d_d.s      = c_q.s;
    d_d.as_err = c_q.as_err;
    d_d.mneg   = c_q.mneg;
    d_d.dn     = c_q.dn;
    d_d.dd     = c_q.dd;
    d_d.qn     = c_q.qn;
    d_d.dfault = c_q.dfault;
    for (int i = 0; i < 2; i++) begin
      d_d.prod[i] = (2*PW)'(c_q.pp[i][0])
                  + ((2*PW)'(c_q.pp[i][1]) << HW)
                  + ((2*PW)'(c_q.pp[i][2]) << HW)
                  + ((2*PW)'(c_q.pp[i][3]) << PW);
    end
  end

  // stage E: product range check and sign
  always_comb begin
    e_d.cmd    = d_q.cmd;
    e_d.a      = d_q.a;
    e_d.s      = d_q.s;
    e_d.as_err = d_q.as_err;
    e_d.mneg   = d_q.mneg;
    e_d.dn     = d_q.dn;
    e_d.dd     = d_q.dd;
    e_d.qn     = d_q.qn;
    e_d.dfault = d_q.dfault;
    for (int i = 0; i < 2; i++) begin
      e_d.mok[i] = (d_q.prod[i][2*PW-1:W-1] == '0) ||
                   (d_q.mneg[i] && d_q.prod[i] == MinMag);
      e_d.t[i]   = d_q.mneg[i] ? (~d_q.prod[i][W-1:0] + 1'b1) : d_q.prod[i][W-1:0];
    end
  end

  // stage F: dot/cross sum, result and status for all but the quotient
  always_comb begin
    logic [W:0] sd;
    logic       sovf;
    if (e_q.cmd == CmdCross) begin
      sd = {e_q.t[0][W-1], e_q.t[0]} - {e_q.t[1][W-1], e_q.t[1]};
    end else begin
      sd = {e_q.t[0][W-1], e_q.t[0]} + {e_q.t[1][W-1], e_q.t[1]};
    end
    sovf      = !(&e_q.mok) || (sd[W] ^ sd[W-1]);
    f_d.r     = e_q.a;
    f_d.sc    = '0;
    f_d.st    = StOk;
    f_d.isdiv = 1'b0;
    f_d.qn    = e_q.qn;
    f_d.dd    = e_q.dd;
    f_d.acc[0] = {{W{1'b0}}, e_q.dn[0]};
    f_d.acc[1] = {{W{1'b0}}, e_q.dn[1]};
    unique case (e_q.cmd)
      CmdAdd: begin
        if (e_q.as_err) f_d.st = StOvf;
        else f_d.r = e_q.s;
      end
      CmdSub: begin
        if (e_q.as_err) f_d.st = StUnf;
        else f_d.r = e_q.s;
      end
      CmdMul: begin
        if (&e_q.mok) f_d.r = e_q.t;
        else f_d.st = StOvf;
      end
      CmdDiv: begin
        if (e_q.dfault) f_d.st = StDiv;
        else f_d.isdiv = 1'b1;
      end
      CmdDot, CmdCross: begin
        if (sovf) f_d.st = StSovf;
        else f_d.sc = sd[W-1:0];
      end
      default: begin
        f_d.st = StOk;
      end
    endcase
  end

  // output stage: signed quotient select, sign extension to field width
  always_comb begin
    logic [1:0][W-1:0] q;
    logic [1:0][W-1:0] v;
    for (int i = 0; i < 2; i++) begin
      q[i] = dv_q[W-1].acc[i][W-1:0];
      if (dv_q[W-1].qn[i]) q[i] = ~q[i] + 1'b1;
      v[i] = dv_q[W-1].isdiv ? q[i] : dv_q[W-1].r[i];
    end
    m_d.vx = FieldW'(signed'(v[0]));
    m_d.vy = FieldW'(signed'(v[1]));
    m_d.sc = FieldW'(signed'(dv_q[W-1].sc));
    m_d.st = dv_q[W-1].st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      e_vld_q  <= 1'b0;
      f_vld_q  <= 1'b0;
      dv_vld_q <= '0;
      m_vld_q  <= 1'b0;
    end else if (en) begin
      a_vld_q  <= s_axis_tvalid;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= c_vld_q;
      e_vld_q  <= d_vld_q;
      f_vld_q  <= e_vld_q;
      dv_vld_q <= {dv_vld_q[W-2:0], f_vld_q};
      m_vld_q  <= dv_vld_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q.cmd  <= s_axis_tuser;
      a_q.a[0] <= s_axis_tdata[0*FieldW +: W];
      a_q.a[1] <= s_axis_tdata[1*FieldW +: W];
      a_q.b[0] <= s_axis_tdata[2*FieldW +: W];
      a_q.b[1] <= s_axis_tdata[3*FieldW +: W];
      b_q      <= b_d;
      c_q      <= c_d;
      d_q      <= d_d;
      e_q      <= e_d;
      f_q      <= f_d;
      dv_q[0]  <= dstage(f_q);
      for (int k = 1; k < W; k++) begin
        dv_q[k] <= dstage(dv_q[k-1]);
      end
      m_q      <= m_d;
    end
  end

`ifndef SYNTHESIS
  a_sc_zero_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && m_q.st != StOk |-> m_q.sc == '0)
    else $error("scalar result not zero on faulted transfer");

  a_div_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld_q && f_q.isdiv |-> f_q.st == StOk)
    else $error("quotient selected on faulted divide");

  a_prod_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && e_q.mok[0] && e_q.t[0] != '0 |-> e_q.t[0][W-1] == e_q.mneg[0])
    else $error("in-range product has wrong sign");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(m_q) && $stable(dv_vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
